[rtl/roulette_wheel_selector_assert.svh]
// assertion macros for the rtl
`ifndef ROULETTE_WHEEL_SELECTOR_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTOR_ASSERT_SVH

`ifndef SYNTH
`define RWS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rws assertion failed");
`define RWS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("rws assertion failed");
`else
`define RWS_ASSERT(label, clk, rst_n, prop)
`define RWS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/rws_pkg.sv]
package rws_pkg;

  localparam int SLOT_W      = 7;
  localparam int FIT_W       = 31;
  localparam int SUM_W       = 38;
  localparam int POP_W       = 8;
  localparam int MAX_POP_DEF = 128;
  localparam logic [POP_W-1:0] POP_RESET = 8'd128;

  // configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam logic REG_POP_SIZE = 1'b0;

  // item commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  // control from the walk sequencer to the accumulator
  typedef struct packed {
    logic clr;
    logic vld;
  } acc_ctl_t;

  typedef struct packed {
    logic hit;
    logic found;
  } acc_stat_t;

endpackage

[rtl/rws_in_if.sv]
interface rws_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [rws_pkg::SLOT_W-1:0]   slot;
  logic [rws_pkg::FIT_W-1:0]    fitness_value;
  logic [rws_pkg::SUM_W-1:0]    draw_point;
  logic [rws_pkg::SLOT_W-1:0]   fallback_slot;

  modport source (output valid, cmd, slot, fitness_value, draw_point, fallback_slot,
                  input ready);
  modport sink (input valid, cmd, slot, fitness_value, draw_point, fallback_slot,
                output ready);
endinterface

[rtl/rws_out_if.sv]
interface rws_out_if;
  logic                         valid;
  logic                         ready;
  logic [rws_pkg::SLOT_W-1:0]   chosen_slot;
  logic [rws_pkg::SUM_W-1:0]    fitness_sum;

  modport source (output valid, chosen_slot, fitness_sum, input ready);
  modport sink (input valid, chosen_slot, fitness_sum, output ready);
endinterface

[rtl/rws_cfg.sv]
module rws_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rws_pkg::CFG_AW-1:0]  paddr,
  input  logic [rws_pkg::CFG_DW-1:0]  pwdata,
  output logic [rws_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [rws_pkg::POP_W-1:0]   pop_size
);

  logic [rws_pkg::POP_W-1:0] pop_size_r;
  logic                      hit_pop;

  assign hit_pop = (paddr[2] == rws_pkg::REG_POP_SIZE);
  assign pready  = 1'b1;
  assign prdata  = hit_pop ? rws_pkg::CFG_DW'(pop_size_r) : '0;
  assign pop_size = pop_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_size_r <= rws_pkg::POP_RESET;
    end else if (psel && penable && pwrite && hit_pop) begin
      pop_size_r <= pwdata[rws_pkg::POP_W-1:0];
    end
  end

endmodule

[rtl/rws_accum.sv]
module rws_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rws_pkg::acc_ctl_t           ctl,
  input  logic [rws_pkg::FIT_W-1:0]   fit,
  input  logic [rws_pkg::SUM_W-1:0]   point,
  output logic [rws_pkg::SUM_W-1:0]   acc,
  output rws_pkg::acc_stat_t          stat
);

  logic [rws_pkg::SUM_W-1:0] acc_r;
  logic [rws_pkg::SUM_W-1:0] acc_nxt;
  logic [rws_pkg::SUM_W:0]   sum;
  logic                      found_r;

  // saturating add of one stored fitness
  assign sum     = {1'b0, acc_r} + (rws_pkg::SUM_W+1)'(fit);
  assign acc_nxt = sum[rws_pkg::SUM_W] ? '1 : sum[rws_pkg::SUM_W-1:0];

  assign stat.hit   = ctl.vld && !found_r && (acc_nxt >= point);
  assign stat.found = found_r;
  assign acc        = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      acc_r   <= '0;
    end else if (ctl.clr) begin
      found_r <= 1'b0;
      acc_r   <= '0;
    end else if (ctl.vld) begin
      acc_r <= acc_nxt;
      if (stat.hit) begin
        found_r <= 1'b1;
      end
    end
  end

endmodule

[rtl/roulette_wheel_selector.sv]
// channel  | dir | beat contents
// in_ch    | in  | cmd, slot, fitness_value, draw_point, fallback_slot
// out_ch   | out | chosen_slot, fitness_sum (one beat per select, none per load)
// cfg_*    | in  | apb write/read of population_size at byte address 0
//
// a load beat writes the fitness ram and the block is ready again
// a select reads the ram once per slot in use, waits on the registered read data, then
//   hands the result to the output register
// after reset a clearing pass zeroes the fitness ram, input not ready
// a waiting result sits in the output register; loads are still taken meanwhile,
//   a later select holds in its final cycle until the register frees up
`include "roulette_wheel_selector_assert.svh"

module roulette_wheel_selector #(
  parameter int MAX_POP = rws_pkg::MAX_POP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rws_in_if.sink                      in_ch,
  rws_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rws_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [rws_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [rws_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
  localparam int NW = $clog2(MAX_POP + 1);
  // width for slot counts and compares against population_size
  localparam int CW = (NW > rws_pkg::POP_W) ? NW : rws_pkg::POP_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // configuration register
  logic [rws_pkg::POP_W-1:0] pop_size;

  rws_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .pop_size (pop_size)
  );

  // slots in use: zero counts as one, capped at MAX_POP
  logic [CW-1:0] pop_ext;
  logic [CW-1:0] n_use;
  logic [AW-1:0] last_use;
  logic [CW-1:0] fb_ext;
  logic [AW-1:0] fb_sel;

  assign pop_ext  = CW'(pop_size);
  assign n_use    = (pop_ext == '0) ? CW'(1) :
                    (pop_ext > CW'(MAX_POP)) ? CW'(MAX_POP) : pop_ext;
  assign last_use = AW'(n_use - CW'(1));
  assign fb_ext   = CW'(in_ch.fallback_slot);
  // a fallback outside the population saturates to the last slot in use
  assign fb_sel   = (fb_ext < n_use) ? AW'(fb_ext) : last_use;

  // input handshake
  logic in_beat;
  logic load_beat;
  logic sel_beat;
  logic slot_ok;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign load_beat   = in_beat && (in_ch.cmd == rws_pkg::CMD_LOAD);
  assign sel_beat    = in_beat && (in_ch.cmd == rws_pkg::CMD_SELECT);
  // loads beyond the store are dropped
  assign slot_ok     = (CW'(in_ch.slot) < CW'(MAX_POP));

  // walk counters
  logic [AW-1:0] clr_r;
  logic [AW-1:0] iss_r;
  logic          iss_act_r;
  logic          dvld_r;
  logic [AW-1:0] pidx_r;
  logic [AW-1:0] last_r;
  logic [AW-1:0] fb_r;
  logic [AW-1:0] chosen_r;
  logic [rws_pkg::SUM_W-1:0] point_r;

  // fitness ram: one write port, one registered read port
  logic [rws_pkg::FIT_W-1:0] mem [MAX_POP];
  logic [rws_pkg::FIT_W-1:0] rd_data_r;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [rws_pkg::FIT_W-1:0] wr_data;
  logic                      rd_en;

  assign wr_en   = (state_r == ST_CLEAR) || (load_beat && slot_ok);
  assign wr_addr = (state_r == ST_CLEAR) ? clr_r : AW'(in_ch.slot);
  assign wr_data = (state_r == ST_CLEAR) ? '0 : in_ch.fitness_value;
  assign rd_en   = (state_r == ST_WALK) && iss_act_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[iss_r];
    end
  end

  // running cumulative sum and first-hit detect
  rws_pkg::acc_ctl_t         acc_ctl;
  rws_pkg::acc_stat_t        acc_stat;
  logic [rws_pkg::SUM_W-1:0] acc;

  assign acc_ctl.clr = sel_beat;
  assign acc_ctl.vld = dvld_r;

  rws_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .fit   (rd_data_r),
    .point (point_r),
    .acc   (acc),
    .stat  (acc_stat)
  );

  // result: a zero in-use total falls back to the caller's slot
  logic          out_valid_r;
  logic [rws_pkg::SLOT_W-1:0] out_slot_r;
  logic [rws_pkg::SUM_W-1:0]  out_sum_r;
  logic [AW-1:0] chosen_fin;
  logic          out_free;

  assign chosen_fin = (acc == '0) ? fb_r : chosen_r;
  assign out_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.chosen_slot = out_slot_r;
  assign out_ch.fitness_sum = out_sum_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(MAX_POP - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (sel_beat) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (dvld_r && (pidx_r == last_r)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      iss_act_r   <= 1'b0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      // the accumulate of a slot comes in the cycle after its read issue
      dvld_r <= rd_en;
      if (sel_beat) begin
        iss_act_r <= 1'b1;
      end else if (rd_en && (iss_r == last_r)) begin
        iss_act_r <= 1'b0;
      end
      // a new result may replace one taken in the same cycle
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    if (sel_beat) begin
      iss_r    <= '0;
      last_r   <= last_use;
      fb_r     <= fb_sel;
      chosen_r <= last_use;
      point_r  <= in_ch.draw_point;
    end else if (rd_en) begin
      iss_r <= iss_r + AW'(1);
    end
    pidx_r <= iss_r;
    if (acc_stat.hit) begin
      chosen_r <= pidx_r;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_slot_r <= rws_pkg::SLOT_W'(chosen_fin);
      out_sum_r  <= acc;
    end
  end

  // a result only enters the output register from the finish state
  `RWS_ASSERT(a_out_from_fin, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
  // the read pointer never runs past the last slot in use
  `RWS_ASSERT(a_iss_in_range, clk, rst_n, rd_en |-> (iss_r <= last_r))
  // the chosen slot always lies within the population
  `RWS_ASSERT(a_chosen_in_range, clk, rst_n, (state_r == ST_FIN) |-> (chosen_fin <= last_r))
  // no ram data is consumed during the clearing pass
  `RWS_ASSERT(a_no_read_in_clear, clk, rst_n, (state_r == ST_CLEAR) |-> !dvld_r && !iss_act_r)

endmodule
